// File: sv/clr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped line rasterizer package
// Shared item kinds, register indexes and the command flag group that
// travels from the front end through the command queue to the stepper.
// ----------------------------------------------------------------------------
package clr_pkg;

    localparam logic KIND_START   = 1'b0;
    localparam logic KIND_ADVANCE = 1'b1;

    localparam logic REG_CLIP_WIDTH  = 1'b0;
    localparam logic REG_CLIP_HEIGHT = 1'b1;

    localparam int CLIP_BITS   = 15;
    localparam int CFG_BITS    = 16;
    localparam int COLOR_BITS  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic kind;
        logic x_negative;
        logic y_negative;
        logic x_major;
    } cmd_flags_t;

    localparam int FLAGS_BITS = $bits(cmd_flags_t);

endpackage
`default_nettype wire

// File: sv/clr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped line rasterizer front end
// Registers each input transfer, works out the line's axis lengths and step
// directions, and hands a classified command to the command queue.
// ----------------------------------------------------------------------------
module clr_front #(
    parameter int COORD_BITS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire                                  in_kind,
    input  wire  [COORD_BITS-1:0]                in_start_x,
    input  wire  [COORD_BITS-1:0]                in_start_y,
    input  wire  [COORD_BITS-1:0]                in_end_x,
    input  wire  [COORD_BITS-1:0]                in_end_y,
    input  wire  [clr_pkg::COLOR_BITS-1:0]       in_color,
    output logic                                 push_valid,
    input  wire                                  push_ready,
    output clr_pkg::cmd_flags_t                  push_flags,
    output logic [COORD_BITS-1:0]                push_start_x,
    output logic [COORD_BITS-1:0]                push_start_y,
    output logic [COORD_BITS-1:0]                push_len_x,
    output logic [COORD_BITS-1:0]                push_len_y,
    output logic [clr_pkg::COLOR_BITS-1:0]       push_color
);

    logic                           valid_reg, valid_next;
    logic                           kind_reg;
    logic                           xneg_reg, yneg_reg;
    logic [COORD_BITS-1:0]          sx_reg, sy_reg, adx_reg, ady_reg;
    logic [clr_pkg::COLOR_BITS-1:0] color_reg;

    logic signed [COORD_BITS:0] sx_ext, sy_ext, ex_ext, ey_ext;
    logic signed [COORD_BITS:0] dx_pos, dx_neg, dy_pos, dy_neg;
    logic                       xneg_next, yneg_next;
    logic                       load;

    assign in_ready = !valid_reg || push_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        sx_ext    = $signed({in_start_x[COORD_BITS-1], in_start_x});
        sy_ext    = $signed({in_start_y[COORD_BITS-1], in_start_y});
        ex_ext    = $signed({in_end_x[COORD_BITS-1], in_end_x});
        ey_ext    = $signed({in_end_y[COORD_BITS-1], in_end_y});
        dx_pos    = ex_ext - sx_ext;
        dx_neg    = sx_ext - ex_ext;
        dy_pos    = ey_ext - sy_ext;
        dy_neg    = sy_ext - ey_ext;
        xneg_next = sx_ext > ex_ext;
        yneg_next = sy_ext > ey_ext;
        if (load) begin
            valid_next = 1'b1;
        end else if (push_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= in_kind;
            sx_reg    <= in_start_x;
            sy_reg    <= in_start_y;
            xneg_reg  <= xneg_next;
            yneg_reg  <= yneg_next;
            adx_reg   <= xneg_next ? dx_neg[COORD_BITS-1:0] : dx_pos[COORD_BITS-1:0];
            ady_reg   <= yneg_next ? dy_neg[COORD_BITS-1:0] : dy_pos[COORD_BITS-1:0];
            color_reg <= in_color;
        end
    end

    always_comb begin
        push_valid            = valid_reg;
        push_flags.kind       = kind_reg;
        push_flags.x_negative = xneg_reg;
        push_flags.y_negative = yneg_reg;
        push_flags.x_major    = adx_reg > ady_reg;
        push_start_x          = sx_reg;
        push_start_y          = sy_reg;
        push_len_x            = adx_reg;
        push_len_y            = ady_reg;
        push_color            = color_reg;
    end

endmodule
`default_nettype wire

// File: sv/clr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped line rasterizer command queue
// A short first-in first-out queue in flip-flops that decouples the front
// end from the stepper, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module clr_queue #(
    parameter int DATA_W = 108
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               wr_valid,
    output logic              wr_ready,
    input  wire  [DATA_W-1:0] wr_data,
    output logic              rd_valid,
    input  wire               rd_ready,
    output logic [DATA_W-1:0] rd_data
);

    localparam int PTR_W = $clog2(clr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(clr_pkg::QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [clr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_wr, do_rd;

    assign wr_ready = count_reg != CNT_W'(clr_pkg::QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = entry_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(clr_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// File: sv/clr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped line rasterizer stepper
// Holds line state and clip registers, runs start and advance commands one per
// cycle unless out_ready stalls them, and drives the registered result channel.
// ----------------------------------------------------------------------------
module clr_back #(
    parameter int COORD_BITS = 16
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  cfg_valid,
    input  wire                                  cfg_index,
    input  wire  [clr_pkg::CFG_BITS-1:0]         cfg_data,
    input  wire                                  cmd_valid,
    output logic                                 cmd_ready,
    input  wire  clr_pkg::cmd_flags_t            cmd_flags,
    input  wire  [COORD_BITS-1:0]                cmd_start_x,
    input  wire  [COORD_BITS-1:0]                cmd_start_y,
    input  wire  [COORD_BITS-1:0]                cmd_len_x,
    input  wire  [COORD_BITS-1:0]                cmd_len_y,
    input  wire  [clr_pkg::COLOR_BITS-1:0]       cmd_color,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [COORD_BITS-1:0]                out_x,
    output logic [COORD_BITS-1:0]                out_y,
    output logic [clr_pkg::COLOR_BITS-1:0]       out_color,
    output logic                                 out_drawn,
    output logic                                 out_last
);

    localparam int CMP_W = (COORD_BITS > clr_pkg::CLIP_BITS) ? COORD_BITS
                                                            : clr_pkg::CLIP_BITS;

    logic [clr_pkg::CLIP_BITS-1:0]  clip_w_reg, clip_h_reg;
    logic [COORD_BITS-1:0]          cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]          cur_y_reg, cur_y_next;
    logic [COORD_BITS-1:0]          major_reg, major_next;
    logic [COORD_BITS-1:0]          minor_reg, minor_next;
    logic [COORD_BITS:0]            diff_reg, diff_next;
    logic [COORD_BITS:0]            err_reg, err_next;
    logic [COORD_BITS-1:0]          steps_reg, steps_next;
    logic                           xneg_reg, xneg_next;
    logic                           yneg_reg, yneg_next;
    logic                           xmaj_reg, xmaj_next;
    logic                           active_reg, active_next;
    logic [clr_pkg::COLOR_BITS-1:0] color_reg, color_next;

    logic                           ovalid_reg, ovalid_next;
    logic [COORD_BITS-1:0]          ox_reg, ox_next, oy_reg, oy_next;
    logic [clr_pkg::COLOR_BITS-1:0] ocolor_reg, ocolor_next;
    logic                           odrawn_reg, odrawn_next;
    logic                           olast_reg, olast_next;

    logic                           pop;
    logic [COORD_BITS-1:0]          major_sel, minor_sel;
    logic [COORD_BITS-1:0]          step_x, step_y, adv_x, adv_y;
    logic [COORD_BITS:0]            err_sum;
    logic [COORD_BITS+1:0]          err_trial;
    logic                           minor_step;

    function automatic logic inside_clip(input logic [COORD_BITS-1:0] x,
                                         input logic [COORD_BITS-1:0] y,
                                         input logic [clr_pkg::CLIP_BITS-1:0] w,
                                         input logic [clr_pkg::CLIP_BITS-1:0] h);
        logic x_ok, y_ok;
        x_ok = !x[COORD_BITS-1] && (CMP_W'(x) < CMP_W'(w));
        y_ok = !y[COORD_BITS-1] && (CMP_W'(y) < CMP_W'(h));
        return x_ok && y_ok;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_w_reg <= '0;
            clip_h_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                clr_pkg::REG_CLIP_WIDTH: begin
                    clip_w_reg <= cfg_data[clr_pkg::CLIP_BITS-1:0];
                end
                clr_pkg::REG_CLIP_HEIGHT: begin
                    clip_h_reg <= cfg_data[clr_pkg::CLIP_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cmd_ready = !ovalid_reg || out_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        major_sel  = cmd_flags.x_major ? cmd_len_x : cmd_len_y;
        minor_sel  = cmd_flags.x_major ? cmd_len_y : cmd_len_x;
        step_x     = xneg_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        step_y     = yneg_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        err_sum    = err_reg + {1'b0, minor_reg};
        err_trial  = {1'b0, err_reg} + {diff_reg[COORD_BITS], diff_reg};
        minor_step = !err_trial[COORD_BITS+1] && (err_trial != '0);
        adv_x      = (xmaj_reg || minor_step) ? step_x : cur_x_reg;
        adv_y      = (!xmaj_reg || minor_step) ? step_y : cur_y_reg;

        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        major_next  = major_reg;
        minor_next  = minor_reg;
        diff_next   = diff_reg;
        err_next    = err_reg;
        steps_next  = steps_reg;
        xneg_next   = xneg_reg;
        yneg_next   = yneg_reg;
        xmaj_next   = xmaj_reg;
        active_next = active_reg;
        color_next  = color_reg;

        ovalid_next = ovalid_reg && !out_ready;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        ocolor_next = ocolor_reg;
        odrawn_next = odrawn_reg;
        olast_next  = olast_reg;

        if (pop) begin
            ovalid_next = 1'b1;
            if (cmd_flags.kind == clr_pkg::KIND_START) begin
                cur_x_next  = cmd_start_x;
                cur_y_next  = cmd_start_y;
                major_next  = major_sel;
                minor_next  = minor_sel;
                diff_next   = {1'b0, minor_sel} - {1'b0, major_sel};
                err_next    = '0;
                steps_next  = major_sel;
                xneg_next   = cmd_flags.x_negative;
                yneg_next   = cmd_flags.y_negative;
                xmaj_next   = cmd_flags.x_major;
                active_next = major_sel != '0;
                color_next  = cmd_color;
                ox_next     = cmd_start_x;
                oy_next     = cmd_start_y;
                ocolor_next = cmd_color;
                odrawn_next = inside_clip(cmd_start_x, cmd_start_y, clip_w_reg, clip_h_reg);
                olast_next  = major_sel == '0;
            end else if (active_reg) begin
                cur_x_next  = adv_x;
                cur_y_next  = adv_y;
                err_next    = minor_step ? err_trial[COORD_BITS:0] : err_sum;
                steps_next  = steps_reg - 1'b1;
                active_next = steps_reg != COORD_BITS'(1);
                ox_next     = adv_x;
                oy_next     = adv_y;
                ocolor_next = color_reg;
                odrawn_next = inside_clip(adv_x, adv_y, clip_w_reg, clip_h_reg);
                olast_next  = steps_reg == COORD_BITS'(1);
            end else begin
                ox_next     = cur_x_reg;
                oy_next     = cur_y_reg;
                ocolor_next = color_reg;
                odrawn_next = 1'b0;
                olast_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            major_reg  <= '0;
            minor_reg  <= '0;
            diff_reg   <= '0;
            err_reg    <= '0;
            steps_reg  <= '0;
            xneg_reg   <= 1'b0;
            yneg_reg   <= 1'b0;
            xmaj_reg   <= 1'b0;
            active_reg <= 1'b0;
            color_reg  <= '0;
            ovalid_reg <= 1'b0;
        end else begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            major_reg  <= major_next;
            minor_reg  <= minor_next;
            diff_reg   <= diff_next;
            err_reg    <= err_next;
            steps_reg  <= steps_next;
            xneg_reg   <= xneg_next;
            yneg_reg   <= yneg_next;
            xmaj_reg   <= xmaj_next;
            active_reg <= active_next;
            color_reg  <= color_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        ocolor_reg <= ocolor_next;
        odrawn_reg <= odrawn_next;
        olast_reg  <= olast_next;
    end

    assign out_valid = ovalid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_color = ocolor_reg;
    assign out_drawn = odrawn_reg;
    assign out_last  = olast_reg;

endmodule
`default_nettype wire

// File: sv/clipped_line_rasterizer_unit.sv
`default_nettype none
// Path: each item is registered at the input, held in the command queue and
// registered again at the output before its result is shown.
// Throughput: one item per cycle while m_tready stays high; the stepper does
// one add, compare and select per advance, and the two-entry queue lets
// either side stall alone.
// Reset: aresetn low at a clock edge clears the line state, the clip
// registers and the queue; the block comes up idle.
// ----------------------------------------------------------------------------
// Clipped line rasterizer unit
// Streams Bresenham-style line pixels with a clip test, one result for
// every start or advance item.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire                  cfg_index,
    input  wire  [15:0]          cfg_data,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    // s_tdata from bit 0: start_x, start_y, end_x, end_y, line_color, zero fill
    input  wire  [((4*COORD_BITS+32+7)/8)*8-1:0] s_tdata,
    // s_tuser: kind
    input  wire                  s_tuser,
    output logic                 m_tvalid,
    input  wire                  m_tready,
    // m_tdata from bit 0: pixel_x, pixel_y, pixel_color, zero fill
    output logic [((2*COORD_BITS+32+7)/8)*8-1:0] m_tdata,
    // m_tuser: drawn
    output logic                 m_tuser,
    output logic                 m_tlast
);

    localparam int C      = COORD_BITS;
    localparam int CB     = clr_pkg::COLOR_BITS;
    localparam int M_W    = ((2*COORD_BITS+32+7)/8)*8;
    localparam int Q_W    = clr_pkg::FLAGS_BITS + 4*COORD_BITS + clr_pkg::COLOR_BITS;

    logic                push_valid, push_ready;
    clr_pkg::cmd_flags_t push_flags, pop_flags;
    logic [C-1:0]        push_sx, push_sy, push_lx, push_ly;
    logic [CB-1:0]       push_color;
    logic [Q_W-1:0]      push_data, pop_data;
    logic                pop_valid, pop_ready;
    logic [C-1:0]        out_x, out_y;
    logic [CB-1:0]       out_color;

    assign cfg_ready = 1'b1;

    clr_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_kind     (s_tuser),
        .in_start_x  (s_tdata[C-1:0]),
        .in_start_y  (s_tdata[2*C-1:C]),
        .in_end_x    (s_tdata[3*C-1:2*C]),
        .in_end_y    (s_tdata[4*C-1:3*C]),
        .in_color    (s_tdata[4*C+CB-1:4*C]),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_flags  (push_flags),
        .push_start_x(push_sx),
        .push_start_y(push_sy),
        .push_len_x  (push_lx),
        .push_len_y  (push_ly),
        .push_color  (push_color)
    );

    assign push_data = {push_flags, push_color, push_ly, push_lx, push_sy, push_sx};

    clr_queue #(
        .DATA_W(Q_W)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(push_valid),
        .wr_ready(push_ready),
        .wr_data (push_data),
        .rd_valid(pop_valid),
        .rd_ready(pop_ready),
        .rd_data (pop_data)
    );

    assign pop_flags = pop_data[Q_W-1:4*C+CB];

    clr_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd_valid  (pop_valid),
        .cmd_ready  (pop_ready),
        .cmd_flags  (pop_flags),
        .cmd_start_x(pop_data[C-1:0]),
        .cmd_start_y(pop_data[2*C-1:C]),
        .cmd_len_x  (pop_data[3*C-1:2*C]),
        .cmd_len_y  (pop_data[4*C-1:3*C]),
        .cmd_color  (pop_data[4*C+CB-1:4*C]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_x      (out_x),
        .out_y      (out_y),
        .out_color  (out_color),
        .out_drawn  (m_tuser),
        .out_last   (m_tlast)
    );

    assign m_tdata = M_W'({out_color, out_y, out_x});

endmodule
`default_nettype wire

// File: verif/clipped_line_rasterizer_unit_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Clipped line rasterizer unit testbench
// Drives start and advance items through the input stream and writes the clip
// registers between phases. Every accepted item is traced through a local
// line stepper, and each returned pixel is compared field by field with the
// oldest traced pixel. Both stream sides idle at random, and the receiver
// holds off once for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_unit_test;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic        kind;
        logic [95:0] data;
    } line_cmd_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] color;
        logic        drawn;
        logic        last;
    } pixel_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = clr_pkg::REG_CLIP_WIDTH;
    logic [15:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata   = '0;
    logic        s_tuser   = clr_pkg::KIND_START;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    clipped_line_rasterizer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    line_cmd_t cmd_queue[$];
    pixel_t    pixel_queue[$];
    int        queued_items = 0;
    int        items_taken  = 0;
    int        results_seen = 0;
    int        cfg_taken    = 0;
    int        error_count  = 0;
    int        idle_cycles  = 0;

    int        tx_gap_max = 0;
    int        rx_gap_max = 0;
    int        tx_gap     = 0;
    int        tx_seen    = 0;
    logic      tx_busy    = 1'b0;
    line_cmd_t tx_cmd;
    int        rx_wait    = 0;
    int        rx_hold    = 0;
    int        rx_seen    = 0;
    logic      hold_done  = 1'b0;

    logic [14:0]        clip_w = '0;
    logic [14:0]        clip_h = '0;
    logic signed [15:0] pos_x  = '0;
    logic signed [15:0] pos_y  = '0;
    logic [15:0]        major_span = '0;
    logic [15:0]        minor_span = '0;
    logic [15:0]        steps_remaining = '0;
    logic [16:0]        err_sum = '0;
    logic               step_x_down = 1'b0;
    logic               step_y_down = 1'b0;
    logic               along_x = 1'b0;
    logic               line_busy = 1'b0;
    logic [31:0]        color_reg = '0;

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic logic pixel_in_clip();
        int x;
        int y;
        x = int'(pos_x);
        y = int'(pos_y);
        return x >= 0 && x < int'(clip_w) && y >= 0 && y < int'(clip_h);
    endfunction

    task automatic trace_pixel(input logic kind, input logic [95:0] data);
        int     sx;
        int     sy;
        int     ex;
        int     ey;
        int     dx;
        int     dy;
        logic [15:0] adx;
        logic [15:0] ady;
        pixel_t px;
        px.drawn = 1'b0;
        if (kind == clr_pkg::KIND_START) begin
            sx = int'($signed(data[15:0]));
            sy = int'($signed(data[31:16]));
            ex = int'($signed(data[47:32]));
            ey = int'($signed(data[63:48]));
            dx = ex - sx;
            dy = ey - sy;
            adx = 16'(dx < 0 ? -dx : dx);
            ady = 16'(dy < 0 ? -dy : dy);
            step_x_down = sx > ex;
            step_y_down = sy > ey;
            along_x = adx > ady;
            major_span = along_x ? adx : ady;
            minor_span = along_x ? ady : adx;
            steps_remaining = major_span;
            err_sum = '0;
            pos_x = 16'(sx);
            pos_y = 16'(sy);
            color_reg = data[95:64];
            line_busy = steps_remaining != 0;
            px.drawn = pixel_in_clip();
        end else if (line_busy) begin
            if (along_x) begin
                pos_x = step_x_down ? pos_x - 16'sd1 : pos_x + 16'sd1;
            end else begin
                pos_y = step_y_down ? pos_y - 16'sd1 : pos_y + 16'sd1;
            end
            err_sum = err_sum + {1'b0, minor_span};
            if (err_sum > {1'b0, major_span}) begin
                err_sum = err_sum - {1'b0, major_span};
                if (along_x) begin
                    pos_y = step_y_down ? pos_y - 16'sd1 : pos_y + 16'sd1;
                end else begin
                    pos_x = step_x_down ? pos_x - 16'sd1 : pos_x + 16'sd1;
                end
            end
            steps_remaining = steps_remaining - 16'd1;
            line_busy = steps_remaining != 0;
            px.drawn = pixel_in_clip();
        end
        px.x = pos_x;
        px.y = pos_y;
        px.color = color_reg;
        px.last = !line_busy;
        pixel_queue.push_back(px);
    endtask

    task automatic flag_pixel_error(input string field, input logic [31:0] got,
                                    input logic [31:0] want);
        $display("pixel %0d: %s is %h, %h was due", results_seen, field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && cfg_valid && cfg_ready) begin
            cfg_taken++;
            if (cfg_index == clr_pkg::REG_CLIP_WIDTH) begin
                clip_w = cfg_data[14:0];
            end else begin
                clip_h = cfg_data[14:0];
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            items_taken++;
            trace_pixel(s_tuser, s_tdata);
        end
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pixel_queue.size() == 0) begin
                flag_pixel_error("unexpected transfer", m_tdata[31:0], '0);
            end else begin
                want = pixel_queue.pop_front();
                if (m_tdata[15:0] !== want.x) begin
                    flag_pixel_error("pixel_x", 32'(m_tdata[15:0]), 32'(want.x));
                end
                if (m_tdata[31:16] !== want.y) begin
                    flag_pixel_error("pixel_y", 32'(m_tdata[31:16]), 32'(want.y));
                end
                if (m_tdata[63:32] !== want.color) begin
                    flag_pixel_error("pixel_color", m_tdata[63:32], want.color);
                end
                if (m_tuser !== want.drawn) begin
                    flag_pixel_error("drawn", 32'(m_tuser), 32'(want.drawn));
                end
                if (m_tlast !== want.last) begin
                    flag_pixel_error("last", 32'(m_tlast), 32'(want.last));
                end
            end
        end
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles == STALL_LIMIT) begin
            $display("clipped_line_rasterizer_unit verification failed");
            $finish;
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (tx_busy && items_taken != tx_seen) begin
                tx_busy = 1'b0;
                tx_gap = (tx_gap_max == 0 || rx_hold != 0) ? 0
                                                           : int'($urandom_range(0, tx_gap_max));
            end
            tx_seen = items_taken;
            if (!tx_busy) begin
                if (tx_gap != 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (cmd_queue.size() != 0) begin
                    tx_cmd = cmd_queue.pop_front();
                    s_tuser <= tx_cmd.kind;
                    s_tdata <= tx_cmd.data;
                    s_tvalid <= 1'b1;
                    tx_busy = 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The receiver holds off once for a long stretch while the sender keeps offering items.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (results_seen != rx_seen) begin
                rx_seen = results_seen;
                rx_wait = (rx_gap_max == 0) ? 0 : int'($urandom_range(0, rx_gap_max));
                if (!hold_done && results_seen >= 150) begin
                    hold_done = 1'b1;
                    rx_hold = 80;
                end
            end
            if (rx_hold != 0) begin
                rx_hold--;
                m_tready <= 1'b0;
            end else if (rx_wait != 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic push_start(input logic [15:0] sx, input logic [15:0] sy,
                              input logic [15:0] ex, input logic [15:0] ey,
                              input logic [31:0] color);
        line_cmd_t c;
        c.kind = clr_pkg::KIND_START;
        c.data = {color, ey, ex, sy, sx};
        cmd_queue.push_back(c);
        queued_items++;
    endtask

    task automatic push_advance(input int count);
        line_cmd_t c;
        repeat (count) begin
            c.kind = clr_pkg::KIND_ADVANCE;
            c.data = {$urandom, $urandom, $urandom};
            cmd_queue.push_back(c);
            queued_items++;
        end
    endtask

    task automatic push_noise();
        line_cmd_t c;
        c.kind = $urandom_range(0, 1) ? clr_pkg::KIND_ADVANCE : clr_pkg::KIND_START;
        c.data = {$urandom, $urandom, $urandom};
        cmd_queue.push_back(c);
        queued_items++;
    endtask

    task automatic push_random_line();
        int sx;
        int sy;
        int dx;
        int dy;
        int major;
        int mode;
        mode = int'($urandom_range(0, 19));
        if (mode == 0) begin
            repeat ($urandom_range(1, 3)) push_noise();
        end else if (mode <= 2) begin
            push_start(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       $urandom);
            push_advance(int'($urandom_range(0, 4)));
        end else begin
            sx = int'($urandom_range(0, 110)) - 10;
            sy = int'($urandom_range(0, 110)) - 10;
            dx = int'($urandom_range(0, 48)) - 24;
            dy = int'($urandom_range(0, 48)) - 24;
            major = (dx < 0 ? -dx : dx);
            if ((dy < 0 ? -dy : dy) > major) major = (dy < 0 ? -dy : dy);
            push_start(16'(sx), 16'(sy), 16'(sx + dx), 16'(sy + dy), $urandom);
            if (mode <= 4) begin
                push_advance(int'($urandom_range(0, major)));
            end else if (mode <= 6) begin
                push_advance(major + int'($urandom_range(1, 3)));
            end else begin
                push_advance(major);
            end
        end
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        int seen;
        seen = cfg_taken;
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        while (cfg_taken == seen) @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (cmd_queue.size() != 0 || tx_busy || pixel_queue.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    initial begin
        logic [15:0] w;
        logic [15:0] h;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Advances straight after reset find the block idle.
        push_advance(2);
        drain();
        write_reg(clr_pkg::REG_CLIP_WIDTH, 16'd64);
        write_reg(clr_pkg::REG_CLIP_HEIGHT, 16'd64);
        push_start(16'sd5, 16'sd5, 16'sd5, 16'sd5, 32'hFFFF_FFFF);
        push_start(16'sd0, 16'sd0, 16'sd6, 16'sd2, 32'h0000_0000);
        push_advance(7);
        push_start(16'sd10, 16'sd3, 16'sd8, -16'sd1, 32'hA5A5_5A5A);
        push_advance(4);
        push_start(16'sd0, 16'sd0, -16'sd3, 16'sd3, 32'h1234_5678);
        push_advance(3);
        push_start(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 32'h8000_0001);
        push_advance(2);
        push_start(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 32'h7FFF_FFFE);
        push_advance(1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    w = 16'($urandom_range(40, 100));
                    h = 16'($urandom_range(40, 100));
                end
                1: begin w = 16'hFFFF; h = 16'hFFFF; end
                2: begin w = 16'd0; h = 16'd0; end
                3: begin
                    w = 16'($urandom_range(0, 65535));
                    h = 16'($urandom_range(0, 65535));
                end
                4: begin w = 16'd1; h = 16'd1; end
                5: begin w = 16'h7FFF; h = 16'd0; end
                6: begin w = 16'd0; h = 16'h7FFF; end
                default: begin
                    w = 16'($urandom_range(20, 120));
                    h = 16'($urandom_range(20, 120));
                end
            endcase
            write_reg(clr_pkg::REG_CLIP_HEIGHT, h);
            write_reg(clr_pkg::REG_CLIP_WIDTH, w);
            tx_gap_max = (phase % 3 == 0) ? 0 : 18;
            rx_gap_max = (phase == 0 || phase == 5) ? 0 : 18;
            queued_items = 0;
            while (queued_items < PHASE_ITEMS) push_random_line();
            drain();
        end

        if (error_count == 0) begin
            $display("clipped_line_rasterizer_unit verification clean");
        end else begin
            $display("clipped_line_rasterizer_unit verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
sv/clr_pkg.sv
sv/clr_front.sv
sv/clr_queue.sv
sv/clr_back.sv
sv/clipped_line_rasterizer_unit.sv
verif/clipped_line_rasterizer_unit_test.sv
